// ----- rtl/core/lfos_pkg.sv -----
`timescale 1ns / 1ps

package lfos_pkg;

    localparam int LEVEL_W = 12;
    localparam int DUTY_W  = 13;
    localparam int STOP_W  = 10;
    localparam int CAP_W   = 16;
    localparam int TICK_W  = 32;
    localparam int DIST_W  = 27;
    localparam int REQ_W   = 3;
    localparam int CFG_W   = 3;
    localparam int DATA_W  = 13;

    localparam logic [DUTY_W-1:0]  FULL_DUTY   = 13'd4096;
    localparam logic [LEVEL_W-1:0] WHITE_RESET = 12'd400;
    localparam logic [LEVEL_W-1:0] BLACK_RESET = 12'd3500;
    localparam logic [STOP_W-1:0]  STOP_RESET  = 10'd7;
    localparam logic [DUTY_W-1:0]  FWD_RESET   = 13'd4096;
    localparam logic [DUTY_W-1:0]  TURN_RESET  = 13'd0;

    localparam logic [REQ_W-1:0] REQ_ADC      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_OVERFLOW = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RISE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FALL     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK     = 3'd4;

    localparam logic [CFG_W-1:0] CFG_WHITE_LEVEL  = 3'd0;
    localparam logic [CFG_W-1:0] CFG_BLACK_LEVEL  = 3'd1;
    localparam logic [CFG_W-1:0] CFG_STOP_DIST    = 3'd2;
    localparam logic [CFG_W-1:0] CFG_FORWARD_DUTY = 3'd3;
    localparam logic [CFG_W-1:0] CFG_TURN_DUTY    = 3'd4;

    // Distance = floor(t * 3430 / 20000) = floor((t * 3430 / 32) / 625).
    // The quotient by 625 is split at bit 18: 2^18 = 419 * 625 + 269.
    localparam int PROD_W      = 41;
    localparam int SPLIT_W     = 18;
    localparam int QUO_W       = 18;
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 37;
    localparam logic [DIST_W-1:0]  SPLIT_QUOT = 27'd419;
    localparam logic [DIST_W-1:0]  SPLIT_REM  = 27'd269;
    localparam logic [RECIP_W-1:0] RECIP_625  = 28'd219902326;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [LEVEL_W-1:0] sample_value;
        logic [CAP_W-1:0]   capture_time;
    } t_in_word;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              stop_lamp;
        logic              distance_valid;
        logic [DIST_W-1:0] range_cm;
    } t_out_word;

    typedef struct packed {
        logic               tick;
        logic               take;
        logic [LEVEL_W-1:0] right_level;
        logic [LEVEL_W-1:0] left_level;
    } t_ctl;

endpackage

// ----- rtl/core/line_follower_obstacle_stop.sv -----
`timescale 1ns / 1ps

// Line follower with ultrasonic obstacle stop. Every input word gives exactly one output
// word, in order. A new input word is taken in every cycle in which the output register is
// empty or being emptied; on its way to the output register each word passes through the
// registered chain of constant multipliers that turns the echo interval into centimetres.
// Configuration writes are always accepted and must only be made while no input word is in
// flight.
module line_follower_obstacle_stop (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  lfos_pkg::t_in_word        i_in_word,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output lfos_pkg::t_out_word       o_out_word,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lfos_pkg::CFG_W-1:0]  i_cfg_index,
    input  logic [lfos_pkg::DATA_W-1:0] i_cfg_data
);

    logic                            en;
    logic [5:0]                      r_vld;
    logic                            r_out_vld;
    lfos_pkg::t_out_word             r_out_word;
    lfos_pkg::t_out_word             n_out_word;

    logic [lfos_pkg::LEVEL_W-1:0]    r_white;
    logic [lfos_pkg::LEVEL_W-1:0]    r_black;
    logic [lfos_pkg::STOP_W-1:0]     r_stop_cm;
    logic [lfos_pkg::DUTY_W-1:0]     r_fwd;
    logic [lfos_pkg::DUTY_W-1:0]     r_turn;

    lfos_pkg::t_in_word              r_in;
    logic                            r_sample_slot, n_sample_slot;
    logic [lfos_pkg::LEVEL_W-1:0]    r_right_level, n_right_level;
    logic [lfos_pkg::LEVEL_W-1:0]    r_left_level, n_left_level;
    logic [lfos_pkg::CAP_W-1:0]      r_ovf_count, n_ovf_count;
    logic [lfos_pkg::CAP_W-1:0]      r_rise_time, n_rise_time;
    logic [lfos_pkg::TICK_W-1:0]     r_echo_ticks, n_echo_ticks;
    logic                            r_echo_fresh, n_echo_fresh;
    lfos_pkg::t_ctl                  n_ctl1;

    lfos_pkg::t_ctl                  r_ctl1, r_ctl2, r_ctl3, r_ctl4, r_ctl5;
    logic [lfos_pkg::TICK_W-1:0]     r_ticks1;
    logic [lfos_pkg::TICK_W-1:0]     r_t2;
    logic [lfos_pkg::PROD_W-1:0]     r_p3;
    logic [lfos_pkg::SPLIT_W-1:0]    w_qh;
    logic [lfos_pkg::SPLIT_W-1:0]    w_ql;
    logic [lfos_pkg::DIST_W-1:0]     r_rem4, r_base4;
    logic [lfos_pkg::DIST_W+lfos_pkg::RECIP_W-1:0] w_prod5;
    logic [lfos_pkg::QUO_W-1:0]      r_quo5;
    logic [lfos_pkg::DIST_W-1:0]     r_base5;

    logic                            r_halted, n_halted;
    logic [lfos_pkg::DUTY_W-1:0]     r_left_drive, n_left_drive;
    logic [lfos_pkg::DUTY_W-1:0]     r_right_drive, n_right_drive;
    logic [lfos_pkg::DIST_W-1:0]     r_last_dist, n_last_dist;
    logic [lfos_pkg::DUTY_W-1:0]     w_fwd, w_trn;
    logic [lfos_pkg::DIST_W-1:0]     w_dist;
    logic                            w_rb, w_lb, w_rw, w_lw;

    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white   <= lfos_pkg::WHITE_RESET;
            r_black   <= lfos_pkg::BLACK_RESET;
            r_stop_cm <= lfos_pkg::STOP_RESET;
            r_fwd     <= lfos_pkg::FWD_RESET;
            r_turn    <= lfos_pkg::TURN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lfos_pkg::CFG_WHITE_LEVEL:  r_white   <= i_cfg_data[lfos_pkg::LEVEL_W-1:0];
                lfos_pkg::CFG_BLACK_LEVEL:  r_black   <= i_cfg_data[lfos_pkg::LEVEL_W-1:0];
                lfos_pkg::CFG_STOP_DIST:    r_stop_cm <= i_cfg_data[lfos_pkg::STOP_W-1:0];
                lfos_pkg::CFG_FORWARD_DUTY: r_fwd     <= i_cfg_data;
                lfos_pkg::CFG_TURN_DUTY:    r_turn    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_sample_slot = r_sample_slot;
        n_right_level = r_right_level;
        n_left_level  = r_left_level;
        n_ovf_count   = r_ovf_count;
        n_rise_time   = r_rise_time;
        n_echo_ticks  = r_echo_ticks;
        n_echo_fresh  = r_echo_fresh;
        n_ctl1.tick   = (r_in.req_type == lfos_pkg::REQ_TICK);
        n_ctl1.take   = n_ctl1.tick && r_echo_fresh;
        if (r_vld[0]) begin
            unique case (r_in.req_type)
                lfos_pkg::REQ_ADC: begin
                    if (!r_sample_slot) begin
                        n_right_level = r_in.sample_value;
                    end else begin
                        n_left_level = r_in.sample_value;
                    end
                    n_sample_slot = !r_sample_slot;
                end
                lfos_pkg::REQ_OVERFLOW: begin
                    n_ovf_count = r_ovf_count + 16'd1;
                end
                lfos_pkg::REQ_RISE: begin
                    n_rise_time = r_in.capture_time;
                    n_ovf_count = '0;
                end
                lfos_pkg::REQ_FALL: begin
                    n_echo_ticks = {r_ovf_count, 16'd0} + 32'(r_in.capture_time)
                                   - 32'(r_rise_time);
                    n_echo_fresh = 1'b1;
                end
                lfos_pkg::REQ_TICK: begin
                    n_echo_fresh = 1'b0;
                end
                default: begin
                end
            endcase
        end
        n_ctl1.right_level = n_right_level;
        n_ctl1.left_level  = n_left_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_sample_slot <= 1'b0;
            r_right_level <= '0;
            r_left_level  <= '0;
            r_ovf_count   <= '0;
            r_rise_time   <= '0;
            r_echo_ticks  <= '0;
            r_echo_fresh  <= 1'b0;
        end else if (en) begin
            r_vld         <= {r_vld[4:0], i_in_valid};
            r_sample_slot <= n_sample_slot;
            r_right_level <= n_right_level;
            r_left_level  <= n_left_level;
            r_ovf_count   <= n_ovf_count;
            r_rise_time   <= n_rise_time;
            r_echo_ticks  <= n_echo_ticks;
            r_echo_fresh  <= n_echo_fresh;
        end
    end

    assign w_qh    = r_p3[lfos_pkg::PROD_W-1:lfos_pkg::PROD_W-lfos_pkg::SPLIT_W];
    assign w_ql    = r_p3[lfos_pkg::PROD_W-lfos_pkg::SPLIT_W-1:5];
    assign w_prod5 = (lfos_pkg::DIST_W+lfos_pkg::RECIP_W)'(r_rem4)
                     * (lfos_pkg::DIST_W+lfos_pkg::RECIP_W)'(lfos_pkg::RECIP_625);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in     <= i_in_word;
            r_ctl1   <= n_ctl1;
            r_ticks1 <= n_echo_ticks;
            r_ctl2   <= r_ctl1;
            r_t2     <= 32'(r_ticks1 * 32'd10);
            r_ctl3   <= r_ctl2;
            r_p3     <= lfos_pkg::PROD_W'(r_t2) * lfos_pkg::PROD_W'(343);
            r_ctl4   <= r_ctl3;
            r_rem4   <= lfos_pkg::DIST_W'(w_qh) * lfos_pkg::SPLIT_REM
                        + lfos_pkg::DIST_W'(w_ql);
            r_base4  <= lfos_pkg::DIST_W'(w_qh) * lfos_pkg::SPLIT_QUOT;
            r_ctl5   <= r_ctl4;
            r_quo5   <= w_prod5[lfos_pkg::RECIP_SHIFT+lfos_pkg::QUO_W-1:lfos_pkg::RECIP_SHIFT];
            r_base5  <= r_base4;
        end
    end

    always_comb begin
        w_fwd  = (r_fwd > lfos_pkg::FULL_DUTY) ? lfos_pkg::FULL_DUTY : r_fwd;
        w_trn  = (r_turn > lfos_pkg::FULL_DUTY) ? lfos_pkg::FULL_DUTY : r_turn;
        w_rb   = r_ctl5.right_level >= r_black;
        w_lb   = r_ctl5.left_level >= r_black;
        w_rw   = r_ctl5.right_level <= r_white;
        w_lw   = r_ctl5.left_level <= r_white;
        w_dist = r_base5 + lfos_pkg::DIST_W'(r_quo5);

        n_halted      = r_halted;
        n_left_drive  = r_left_drive;
        n_right_drive = r_right_drive;
        n_last_dist   = r_last_dist;
        if (r_ctl5.tick) begin
            if (!r_halted) begin
                priority if (w_rw && w_lw) begin
                    n_left_drive  = w_trn;
                    n_right_drive = w_trn;
                end else if (w_rb && !w_lb) begin
                    n_left_drive  = w_trn;
                    n_right_drive = w_fwd;
                end else if (w_lb && !w_rb) begin
                    n_left_drive  = w_fwd;
                    n_right_drive = w_trn;
                end else begin
                    n_left_drive  = w_trn;
                    n_right_drive = w_trn;
                end
            end
            if (r_ctl5.take) begin
                n_last_dist = w_dist;
                if (w_dist <= lfos_pkg::DIST_W'(r_stop_cm)) begin
                    n_left_drive  = lfos_pkg::FULL_DUTY;
                    n_right_drive = lfos_pkg::FULL_DUTY;
                    n_halted      = 1'b1;
                end else begin
                    n_halted = 1'b0;
                end
            end
        end
        n_out_word.left_duty      = n_left_drive;
        n_out_word.right_duty     = n_right_drive;
        n_out_word.stop_lamp      = n_halted;
        n_out_word.distance_valid = r_ctl5.tick && r_ctl5.take;
        n_out_word.range_cm       = n_last_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld     <= 1'b0;
            r_halted      <= 1'b0;
            r_left_drive  <= '0;
            r_right_drive <= '0;
            r_last_dist   <= '0;
        end else if (en) begin
            r_out_vld <= r_vld[5];
            if (r_vld[5]) begin
                r_halted      <= n_halted;
                r_left_drive  <= n_left_drive;
                r_right_drive <= n_right_drive;
                r_last_dist   <= n_last_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld[5]) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

// ----- rtl/core/lfos_checker.sv -----
`timescale 1ns / 1ps

module lfos_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lfos_pkg::t_out_word o_out_word
);

    // A word that is not taken stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // The input side must wait while the output register is full and stalled.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // A stop always shows full duty on both motors.
    a_stop_full_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.stop_lamp |->
            o_out_word.left_duty == lfos_pkg::FULL_DUTY &&
            o_out_word.right_duty == lfos_pkg::FULL_DUTY)
        else $error("stop shown without full duty");

    // Duties never exceed 1.0.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.left_duty <= lfos_pkg::FULL_DUTY &&
            o_out_word.right_duty <= lfos_pkg::FULL_DUTY)
        else $error("duty above full scale");

endmodule

bind line_follower_obstacle_stop lfos_checker u_lfos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
